@@ rtl/rcs_pkg.sv @@
// Shared types, constants and helper functions for the random identifier
// character sampler. No dependencies; every other file but rcs_checker uses this package.
package rcs_pkg;

    localparam int ALPHABET_DEPTH_DEFAULT = 256;
    localparam int QUEUE_DEPTH            = 4;
    localparam int BASE_SET_SIZE          = 64;

    // Input kind carried on s_tuser.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // Configuration register indexes.
    localparam logic [7:0] REG_ALPHABET_SIZE = 8'd0;
    localparam logic [7:0] REG_ID_LENGTH     = 8'd1;

    localparam logic [7:0] RESET_ALPHABET_SIZE = 8'd64;
    localparam logic [7:0] RESET_ID_LENGTH     = 8'd21;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SAMPLE,
        OP_ERROR
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] addr;
        logic [7:0] data;
        logic       last;
    } queue_entry_t;

    // Power of two at or above size, minus one.
    function automatic logic [7:0] sample_mask(input logic [7:0] size);
        logic [7:0] m;
        m = size - 8'd1;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        return m;
    endfunction

    // Default alphabet: A-Z, a-z, 0-9, '-', '_'; zero beyond that.
    function automatic logic [7:0] base_char(input logic [7:0] idx);
        logic [7:0] c;
        case (idx) inside
            [8'd0:8'd25]:  c = 8'h41 + idx;
            [8'd26:8'd51]: c = 8'h61 + (idx - 8'd26);
            [8'd52:8'd61]: c = 8'h30 + (idx - 8'd52);
            8'd62:         c = 8'h2D;
            8'd63:         c = 8'h5F;
            default:       c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/rcs_front.sv @@
// Front end: input beat acceptance, configuration registers, mask/reject
// sampling and the identifier position counter. Uses rcs_pkg.
module rcs_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 queue_full,
    output logic                 push,
    output rcs_pkg::queue_entry_t push_entry
);

    logic [7:0] alphabet_size_reg;
    logic [7:0] id_length_reg;
    logic [7:0] position_reg;
    logic [7:0] position_next;

    logic       accept;
    logic       command;
    logic [7:0] random_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_char;
    logic [7:0] sample_idx;
    logic [7:0] pos_inc;
    logic       size_bad;
    logic       rejected;

    assign s_tready  = !queue_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign command     = s_tuser[0];
    assign random_byte = s_tdata[7:0];
    assign entry_index = s_tdata[15:8];
    assign entry_char  = s_tdata[23:16];

    assign size_bad   = alphabet_size_reg < 8'd2;
    assign sample_idx = random_byte & rcs_pkg::sample_mask(alphabet_size_reg);
    assign rejected   = sample_idx >= alphabet_size_reg;
    assign pos_inc    = position_reg + 8'd1;

    always_comb
    begin
        push_entry.kind = rcs_pkg::OP_SAMPLE;
        push_entry.addr = sample_idx;
        push_entry.data = entry_char;
        push_entry.last = (pos_inc == id_length_reg);
        push          = 1'b0;
        position_next = position_reg;
        if (command == rcs_pkg::CMD_WRITE)
        begin
            push_entry.kind = rcs_pkg::OP_WRITE;
            push_entry.addr = entry_index;
            push_entry.last = 1'b0;
            push            = accept;
        end
        else if (size_bad)
        begin
            push_entry.kind = rcs_pkg::OP_ERROR;
            push_entry.last = 1'b0;
            push            = accept;
        end
        else if (!rejected)
        begin
            push = accept;
            if (accept)
            begin
                position_next = push_entry.last ? 8'd0 : pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_size_reg <= rcs_pkg::RESET_ALPHABET_SIZE;
            id_length_reg     <= rcs_pkg::RESET_ID_LENGTH;
            position_reg      <= 8'd0;
        end
        else
        begin
            position_reg <= position_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rcs_pkg::REG_ALPHABET_SIZE: alphabet_size_reg <= cfg_data;
                    rcs_pkg::REG_ID_LENGTH:     id_length_reg     <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ rtl/rcs_queue.sv @@
// Short FIFO of classified operations between front and back end.
// Uses rcs_pkg for the entry type and its depth.
module rcs_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rcs_pkg::queue_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output rcs_pkg::queue_entry_t head,
    output logic                  empty
);

    localparam int DEPTH = rcs_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    rcs_pkg::queue_entry_t slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CW'(1);
                2'b01:   count_reg <= count_reg - CW'(1);
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/rcs_back.sv @@
// Back end: alphabet store (memory plus written-entry flags), lookup and
// the output register of the result stream. Uses rcs_pkg.
module rcs_back
#(
    parameter int ALPHABET_DEPTH = rcs_pkg::ALPHABET_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcs_pkg::queue_entry_t head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic [0:0]            m_tuser
);

    localparam int AW = $clog2(ALPHABET_DEPTH);

    logic [7:0]                mem [ALPHABET_DEPTH];
    logic [ALPHABET_DEPTH-1:0] written_reg;
    logic [7:0]                rdata_reg;
    logic [7:0]                base_reg;
    logic                      hit_reg;
    logic                      out_valid_reg;
    logic                      out_err_reg;
    logic                      out_last_reg;

    logic [AW-1:0] addr;
    logic          in_range;
    logic          is_write;
    logic          pop_result;
    logic          pop_write;

    assign addr     = head.addr[AW-1:0];
    assign in_range = ({1'b0, head.addr} < 9'(ALPHABET_DEPTH));
    assign is_write = (head.kind == rcs_pkg::OP_WRITE);

    // Writes never wait on the output; results wait for a free output slot.
    assign pop        = !empty && (is_write || !out_valid_reg || m_tready);
    assign pop_write  = pop && is_write;
    assign pop_result = pop && !is_write;

    always_ff @(posedge clk)
    begin
        if (pop_write && in_range)
        begin
            mem[addr] <= head.data;
        end
        if (pop_result)
        begin
            rdata_reg <= mem[addr];
            base_reg  <= (in_range && head.kind == rcs_pkg::OP_SAMPLE)
                         ? rcs_pkg::base_char(head.addr) : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_err_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (pop_write && in_range)
            begin
                written_reg[addr] <= 1'b1;
            end
            if (pop_result)
            begin
                out_valid_reg <= 1'b1;
                out_err_reg   <= (head.kind == rcs_pkg::OP_ERROR);
                out_last_reg  <= head.last;
                hit_reg       <= in_range && written_reg[addr]
                                 && (head.kind == rcs_pkg::OP_SAMPLE);
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = hit_reg ? rdata_reg : base_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_err_reg;

endmodule

@@ rtl/random_id_char_sampler.sv @@
// Top level of the random identifier character sampler.
// Depends on rcs_pkg, rcs_front, rcs_queue and rcs_back.
//
// Usage:
//   s_* carries input beats: s_tuser[0] is the command (0 sample a random
//   byte, 1 write an alphabet entry); s_tdata holds random_byte [7:0],
//   entry_index [15:8] and entry_char [23:16].
//   m_* carries result beats: m_tdata is the character, m_tlast marks the
//   character that completes an identifier, m_tuser[0] flags an alphabet
//   size below two (character then zero).
//   cfg_* writes register 0 (alphabet_size) or 1 (id_length); cfg_ready is
//   always high. Change registers only while the block is idle.
// Throughput: one input beat per cycle while the queue is not full.
// Rejected bytes and entry writes produce no result beat.
// An accepted input beat is written into the queue, then the registered alphabet
// read loads the output register that presents its result beat.
// A four-entry queue decouples input from output: when m_tready is low the
// block keeps taking input until the queue fills, then drops s_tready.
// Reset restores the default 64-character alphabet (via per-entry written
// flags, no clearing pass), size 64, length 21 and the position counter.
module random_id_char_sampler
#(
    parameter int ALPHABET_DEPTH = rcs_pkg::ALPHABET_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // random_byte, entry_index, entry_char
    input  logic [0:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // id_char
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // size_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    rcs_pkg::queue_entry_t push_entry;
    rcs_pkg::queue_entry_t head;
    logic                  push;
    logic                  pop;
    logic                  queue_full;
    logic                  queue_empty;

    rcs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    rcs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .empty      (queue_empty)
    );

    rcs_back #(
        .ALPHABET_DEPTH (ALPHABET_DEPTH)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (queue_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/rcs_checker.sv @@
// Port-level checks for random_id_char_sampler, attached by bind.
// Sees only the top-level ports; no package dependency.
module rcs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tlast) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

    // An error beat carries no character and never ends an identifier.
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0 && !m_tlast))
        else $error("size error beat with character or last");

    // No result right out of reset.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result beat right after reset");

    // Configuration writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind random_id_char_sampler rcs_checker u_rcs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
